[hdl/mhdc_pkg.sv]
// Shared types and constants for the MHD primitive/conserved conversion unit.
package mhdc_pkg;

    localparam int IO_BITS = 32;
    localparam int N_LANES = 10;

    // Lanes that divide by the volume weight; the rest divide by the mass.
    localparam logic [N_LANES-1:0] DEN_IS_VOL = 10'b1001110001;

    typedef enum logic {
        OP_PRIM_TO_CONS = 1'b0,
        OP_CONS_TO_PRIM = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DIV  = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef struct packed {
        logic                      opcode;
        logic signed [IO_BITS-1:0] volume_weight;
        logic signed [IO_BITS-1:0] density_in;
        logic signed [IO_BITS-1:0] vel_x_in;
        logic signed [IO_BITS-1:0] vel_y_in;
        logic signed [IO_BITS-1:0] vel_z_in;
        logic signed [IO_BITS-1:0] field_x_in;
        logic signed [IO_BITS-1:0] field_y_in;
        logic signed [IO_BITS-1:0] field_z_in;
        logic signed [IO_BITS-1:0] scalar_in;
        logic signed [IO_BITS-1:0] cleaning_in;
        logic signed [IO_BITS-1:0] energy_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [IO_BITS-1:0] density_out;
        logic signed [IO_BITS-1:0] vel_x_out;
        logic signed [IO_BITS-1:0] vel_y_out;
        logic signed [IO_BITS-1:0] vel_z_out;
        logic signed [IO_BITS-1:0] field_x_out;
        logic signed [IO_BITS-1:0] field_y_out;
        logic signed [IO_BITS-1:0] field_z_out;
        logic signed [IO_BITS-1:0] scalar_out;
        logic signed [IO_BITS-1:0] cleaning_out;
        logic signed [IO_BITS-1:0] energy_out;
        logic [1:0]                status;
    } t_out_beat;

    typedef struct packed {
        logic energy_mode;
    } t_cfg_beat;

endpackage

[hdl/mhdc_chan_if.sv]
// Valid/ready channel carrying one beat of a given payload type.
interface mhdc_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/mhdc_mul.sv]
// Saturating signed fixed-point multiply, floor rounding (combinational).
module mhdc_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_prod,
    output logic                o_sat
);
    localparam logic signed [W-1:0]   WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W-1:0] PMAX = (2*W)'(WMAX);
    localparam logic signed [2*W-1:0] PMIN = (2*W)'(WMIN);

    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] shifted;

    assign prod    = i_a * i_b;
    assign shifted = prod >>> F;   // arithmetic shift = round toward minus infinity

    always_comb begin
        if (shifted > PMAX) begin
            o_prod = WMAX;
            o_sat  = 1'b1;
        end else if (shifted < PMIN) begin
            o_prod = WMIN;
            o_sat  = 1'b1;
        end else begin
            o_prod = shifted[W-1:0];
            o_sat  = 1'b0;
        end
    end
endmodule

[hdl/mhdc_div_cell.sv]
// One restoring-division step for all lanes, plus the item riding alongside.
module mhdc_div_cell
    import mhdc_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SB = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [N_LANES-1:0][W+F-1:0]    i_num,
    input  logic [N_LANES-1:0][W-1:0]      i_rem,
    input  logic [W-1:0]                   i_den_vol,
    input  logic [W-1:0]                   i_den_mass,
    input  logic [SB-1:0]                  i_side,
    output logic                           o_valid,
    output logic [N_LANES-1:0][W+F-1:0]    o_num,
    output logic [N_LANES-1:0][W-1:0]      o_rem,
    output logic [W-1:0]                   o_den_vol,
    output logic [W-1:0]                   o_den_mass,
    output logic [SB-1:0]                  o_side
);
    localparam int QW = W + F;

    logic                        r_valid;
    logic [N_LANES-1:0][QW-1:0]  r_num, n_num;
    logic [N_LANES-1:0][W-1:0]   r_rem, n_rem;
    logic [W-1:0]                r_den_vol, r_den_mass;
    logic [SB-1:0]               r_side;

    logic [W:0]   rem_sh [N_LANES];
    logic [W-1:0] den    [N_LANES];
    logic [N_LANES-1:0] qbit;

    // shift in the next numerator bit, subtract when it fits,
    // quotient bit enters the numerator register from the bottom
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            den[l]    = DEN_IS_VOL[l] ? i_den_vol : i_den_mass;
            rem_sh[l] = {i_rem[l], i_num[l][QW-1]};
            if (rem_sh[l] >= {1'b0, den[l]}) begin
                qbit[l]  = 1'b1;
                n_rem[l] = W'(rem_sh[l] - {1'b0, den[l]});
            end else begin
                qbit[l]  = 1'b0;
                n_rem[l] = rem_sh[l][W-1:0];
            end
            n_num[l] = {i_num[l][QW-2:0], qbit[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num      <= n_num;
            r_rem      <= n_rem;
            r_den_vol  <= i_den_vol;
            r_den_mass <= i_den_mass;
            r_side     <= i_side;
        end
    end

    assign o_valid    = r_valid;
    assign o_num      = r_num;
    assign o_rem      = r_rem;
    assign o_den_vol  = r_den_vol;
    assign o_den_mass = r_den_mass;
    assign o_side     = r_side;
endmodule

[hdl/mhd_conserved_primitive_convert_unit.sv]
// Top level: MHD primitive <-> conserved variable conversion pipeline.
//
// Usage: one particle per beat on i_in (opcode, volume weight and ten
// quantities, signed Q16.16 on 32-bit fields). Opcode 0 turns primitive into
// conserved values, opcode 1 the reverse. One result beat per input beat on
// o_out, in order, with a status code: ok, zero divisor (wins) or saturated.
// i_cfg carries the energy_mode bit (1 = kinetic term in total energy); it is
// always ready and must be written only when no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. Each beat
// passes through the chain of division cells, one quotient bit per cell,
// followed by seven stages of multiply/add and the output register.
// Stall: the whole pipeline holds while the output register is full and the
// receiver is not ready; i_in.ready follows that, so no beat is taken while
// a finished result waits, even if bubbles sit in front of it.
// Reset clears all valid bits and sets energy_mode to 1.
module mhd_conserved_primitive_convert_unit
    import mhdc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhdc_chan_if.sink   i_cfg,
    mhdc_chan_if.sink   i_in,
    mhdc_chan_if.source o_out
);
    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int QW    = W + F;
    localparam int NCELL = W + F;
    localparam int XW    = (W > IO_BITS) ? W : IO_BITS;

    localparam logic signed [W-1:0]  WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  WMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] XMAX  = XW'(WMAX);
    localparam logic signed [XW-1:0] XMIN  = XW'(WMIN);
    localparam logic [QW-1:0]        QMAX  = {{(F+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0]        QMAX1 = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

    // value slots: 0 volume, 1 density/mass, 2..4 vel, 5..7 field,
    // 8 scalar, 9 psi, 10 energy; lane l divides slot l+1
    typedef struct packed {
        logic               op;
        logic               sat;
        logic               zero;
        logic [10:0][W-1:0] val;
    } t_side;

    localparam int SB = $bits(t_side);

    typedef struct packed {
        logic         sat;
        logic [W-1:0] val;
    } t_sres;

    // per-stage item: r holds results or, in conversion to conserved,
    // the raw operands until they are replaced
    typedef struct packed {
        logic                      op;
        logic                      sat;
        logic                      zero;
        logic [N_LANES-1:0][W-1:0] r;
        logic [W-1:0]              v;
        logic [W-1:0]              rho;
    } t_post;

    function automatic t_sres clamp_in(input logic signed [IO_BITS-1:0] x);
        logic signed [XW-1:0] xe;
        t_sres                res;
        xe = XW'(x);
        if (xe > XMAX) begin
            res = {1'b1, WMAX};
        end else if (xe < XMIN) begin
            res = {1'b1, WMIN};
        end else begin
            res = {1'b0, xe[W-1:0]};
        end
        return res;
    endfunction

    function automatic logic [IO_BITS-1:0] to_io(input logic signed [W-1:0] x);
        logic signed [XW-1:0] xe;
        xe = XW'(x);
        return xe[IO_BITS-1:0];
    endfunction

    function automatic logic [W-1:0] magn(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : x;
    endfunction

    function automatic t_sres addsub(input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b,
                                     input logic sub);
        logic signed [W:0] s;
        t_sres             res;
        s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
        if (s[W] != s[W-1]) begin
            res = {1'b1, s[W] ? WMIN : WMAX};
        end else begin
            res = {1'b0, s[W-1:0]};
        end
        return res;
    endfunction

    function automatic t_sres build_q(input logic [QW-1:0] q, input logic neg);
        t_sres res;
        if (!neg) begin
            res = (q > QMAX) ? {1'b1, WMAX} : {1'b0, q[W-1:0]};
        end else begin
            res = (q > QMAX1) ? {1'b1, WMIN} : {1'b0, W'(-q[W-1:0])};
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic r_energy_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            r_energy_mode <= i_cfg.data.energy_mode;
        end
    end

    // ---------------- flow control ----------------
    logic r_out_vld;
    logic adv;

    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv;

    // ---------------- input conditioning ----------------
    t_sres   in_cl [11];
    t_side   in_side;
    logic signed [IO_BITS-1:0] in_raw [11];
    logic [10:0] in_csat;

    assign in_raw[0]  = i_in.data.volume_weight;
    assign in_raw[1]  = i_in.data.density_in;
    assign in_raw[2]  = i_in.data.vel_x_in;
    assign in_raw[3]  = i_in.data.vel_y_in;
    assign in_raw[4]  = i_in.data.vel_z_in;
    assign in_raw[5]  = i_in.data.field_x_in;
    assign in_raw[6]  = i_in.data.field_y_in;
    assign in_raw[7]  = i_in.data.field_z_in;
    assign in_raw[8]  = i_in.data.scalar_in;
    assign in_raw[9]  = i_in.data.cleaning_in;
    assign in_raw[10] = i_in.data.energy_in;

    always_comb begin
        for (int k = 0; k < 11; k++) begin
            in_cl[k]      = clamp_in(in_raw[k]);
            in_side.val[k] = in_cl[k].val;
            in_csat[k]    = in_cl[k].sat;
        end
        in_side.op   = (t_opcode'(i_in.data.opcode) == OP_CONS_TO_PRIM);
        in_side.sat  = |in_csat;
        in_side.zero = in_side.op && ((in_side.val[0] == '0) || (in_side.val[1] == '0));
    end

    // ---------------- division chain ----------------
    logic                        c_vld  [NCELL+1];
    logic [N_LANES-1:0][QW-1:0]  c_num  [NCELL+1];
    logic [N_LANES-1:0][W-1:0]   c_rem  [NCELL+1];
    logic [W-1:0]                c_dvol [NCELL+1];
    logic [W-1:0]                c_dms  [NCELL+1];
    logic [SB-1:0]               c_side [NCELL+1];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            c_num[0][l] = {magn(in_side.val[l+1]), {F{1'b0}}};
            c_rem[0][l] = '0;
        end
    end

    assign c_vld[0]  = i_in.valid;
    assign c_dvol[0] = magn(in_side.val[0]);
    assign c_dms[0]  = magn(in_side.val[1]);
    assign c_side[0] = in_side;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mhdc_div_cell #(
            .W  (W),
            .F  (F),
            .SB (SB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_valid    (c_vld[g]),
            .i_num      (c_num[g]),
            .i_rem      (c_rem[g]),
            .i_den_vol  (c_dvol[g]),
            .i_den_mass (c_dms[g]),
            .i_side     (c_side[g]),
            .o_valid    (c_vld[g+1]),
            .o_num      (c_num[g+1]),
            .o_rem      (c_rem[g+1]),
            .o_den_vol  (c_dvol[g+1]),
            .o_den_mass (c_dms[g+1]),
            .o_side     (c_side[g+1])
        );
    end

    // ---------------- P0: quotient sign, zero divisor, saturation ----------------
    t_side       end_side;
    t_post       n_p0, r_p0;
    t_sres       q_res [N_LANES];
    logic [N_LANES-1:0] q_sat;
    logic [W-1:0] q_a   [N_LANES];
    logic [W-1:0] q_b   [N_LANES];

    assign end_side = c_side[NCELL];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            q_a[l] = end_side.val[l+1];
            q_b[l] = DEN_IS_VOL[l] ? end_side.val[0] : end_side.val[1];
            if (q_b[l] == '0) begin
                q_res[l] = {1'b0, q_a[l][W-1] ? WMIN : WMAX};
            end else begin
                q_res[l] = build_q(c_num[NCELL][l], q_a[l][W-1] ^ q_b[l][W-1]);
            end
            q_sat[l]  = q_res[l].sat;
            n_p0.r[l] = end_side.op ? q_res[l].val : q_a[l];
        end
        n_p0.op   = end_side.op;
        n_p0.zero = end_side.zero;
        n_p0.sat  = end_side.sat | (end_side.op & (|q_sat));
        n_p0.v    = end_side.val[0];
        n_p0.rho  = end_side.val[1];
    end

    // ---------------- P1: mass, field*volume, squares ----------------
    logic [W-1:0] m1_p;
    logic         m1_s;
    logic [W-1:0] fb_p [3];
    logic [2:0]   fb_s;
    logic [W-1:0] sq_p [6];
    logic [5:0]   sq_s;
    t_post        n_p1, r_p1;
    logic [W-1:0] r_sq1 [6];

    mhdc_mul #(.W(W), .F(F)) u_mul_mass (
        .i_a (r_p0.r[0]), .i_b (r_p0.v), .o_prod (m1_p), .o_sat (m1_s)
    );

    for (genvar g = 0; g < 3; g++) begin : g_fld
        mhdc_mul #(.W(W), .F(F)) u_mul (
            .i_a (r_p0.r[g+4]), .i_b (r_p0.v), .o_prod (fb_p[g]), .o_sat (fb_s[g])
        );
    end

    for (genvar g = 0; g < 6; g++) begin : g_sq
        mhdc_mul #(.W(W), .F(F)) u_mul (
            .i_a (r_p0.r[g+1]), .i_b (r_p0.r[g+1]), .o_prod (sq_p[g]), .o_sat (sq_s[g])
        );
    end

    always_comb begin
        n_p1 = r_p0;
        if (!r_p0.op) begin
            n_p1.r[0] = m1_p;
            n_p1.r[4] = fb_p[0];
            n_p1.r[5] = fb_p[1];
            n_p1.r[6] = fb_p[2];
        end
        n_p1.sat = r_p0.sat | (!r_p0.op & (m1_s | (|fb_s)))
                 | (r_energy_mode & (|sq_s[2:0])) | (|sq_s[5:3]);
    end

    // ---------------- P2: momentum and conserved scalars, first sums ----------------
    logic [W-1:0] pm_p [5];
    logic [4:0]   pm_s;
    t_sres        sk1, sb1;
    t_post        n_p2, r_p2;
    logic [W-1:0] r_t2 [4];

    for (genvar g = 0; g < 5; g++) begin : g_mom
        localparam int IDX = (g < 3) ? g + 1 : g + 4;
        mhdc_mul #(.W(W), .F(F)) u_mul (
            .i_a (r_p1.r[IDX]), .i_b (r_p1.r[0]), .o_prod (pm_p[g]), .o_sat (pm_s[g])
        );
    end

    always_comb begin
        sk1  = addsub(r_sq1[0], r_sq1[1], 1'b0);
        sb1  = addsub(r_sq1[3], r_sq1[4], 1'b0);
        n_p2 = r_p1;
        if (!r_p1.op) begin
            n_p2.r[1] = pm_p[0];
            n_p2.r[2] = pm_p[1];
            n_p2.r[3] = pm_p[2];
            n_p2.r[7] = pm_p[3];
            n_p2.r[8] = pm_p[4];
        end
        n_p2.sat = r_p1.sat | (!r_p1.op & (|pm_s)) | (r_energy_mode & sk1.sat) | sb1.sat;
    end

    // ---------------- P3: final sums and halving ----------------
    t_sres        sk2, sb2;
    t_post        n_p3, r_p3;
    logic [W-1:0] r_t3 [2];

    always_comb begin
        sk2      = addsub(r_t2[0], r_t2[1], 1'b0);
        sb2      = addsub(r_t2[2], r_t2[3], 1'b0);
        n_p3     = r_p2;
        n_p3.sat = r_p2.sat | (r_energy_mode & sk2.sat) | sb2.sat;
    end

    // ---------------- P4: kinetic term times density ----------------
    logic [W-1:0] k_p;
    logic         k_s;
    t_post        n_p4, r_p4;
    logic [W-1:0] r_k4, r_hb4;

    mhdc_mul #(.W(W), .F(F)) u_mul_kin (
        .i_a    (r_t3[0]),
        .i_b    (r_p3.op ? r_p3.r[0] : r_p3.rho),
        .o_prod (k_p),
        .o_sat  (k_s)
    );

    always_comb begin
        n_p4     = r_p3;
        n_p4.sat = r_p3.sat | (r_energy_mode & k_s);
    end

    // ---------------- P5: add or remove kinetic term ----------------
    t_sres        e1;
    t_post        n_p5, r_p5;
    logic [W-1:0] n_e5, r_e5, r_hb5;

    always_comb begin
        e1   = addsub(r_p4.r[9], r_k4, r_p4.op);
        n_p5 = r_p4;
        if (r_energy_mode) begin
            n_e5     = e1.val;
            n_p5.sat = r_p4.sat | e1.sat;
        end else begin
            n_e5 = r_p4.r[9];
        end
    end

    // ---------------- P6: add or remove magnetic term ----------------
    t_sres        e2;
    t_post        n_p6, r_p6;
    logic [W-1:0] r_e6;

    always_comb begin
        e2       = addsub(r_e5, r_hb5, r_p5.op);
        n_p6     = r_p5;
        n_p6.sat = r_p5.sat | e2.sat;
    end

    // ---------------- P7: energy times volume, output register ----------------
    logic [W-1:0] ef_p;
    logic         ef_s;
    logic [W-1:0] fin_e;
    logic         fin_sat;
    t_out_beat    n_out, r_out;

    mhdc_mul #(.W(W), .F(F)) u_mul_en (
        .i_a (r_e6), .i_b (r_p6.v), .o_prod (ef_p), .o_sat (ef_s)
    );

    always_comb begin
        fin_e   = r_p6.op ? r_e6 : ef_p;
        fin_sat = r_p6.sat | (!r_p6.op & ef_s);
        n_out.density_out  = to_io(r_p6.r[0]);
        n_out.vel_x_out    = to_io(r_p6.r[1]);
        n_out.vel_y_out    = to_io(r_p6.r[2]);
        n_out.vel_z_out    = to_io(r_p6.r[3]);
        n_out.field_x_out  = to_io(r_p6.r[4]);
        n_out.field_y_out  = to_io(r_p6.r[5]);
        n_out.field_z_out  = to_io(r_p6.r[6]);
        n_out.scalar_out   = to_io(r_p6.r[7]);
        n_out.cleaning_out = to_io(r_p6.r[8]);
        n_out.energy_out   = to_io(fin_e);
        if (r_p6.zero) begin
            n_out.status = ST_ZERO_DIV;
        end else if (fin_sat) begin
            n_out.status = ST_SATURATED;
        end else begin
            n_out.status = ST_OK;
        end
    end

    // ---------------- pipeline registers ----------------
    logic [6:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[5:0], c_vld[NCELL]};
            r_out_vld <= r_vld[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            for (int k = 0; k < 6; k++) begin
                r_sq1[k] <= sq_p[k];
            end
            r_p2    <= n_p2;
            r_t2[0] <= sk1.val;
            r_t2[1] <= r_sq1[2];
            r_t2[2] <= sb1.val;
            r_t2[3] <= r_sq1[5];
            r_p3    <= n_p3;
            r_t3[0] <= {sk2.val[W-1], sk2.val[W-1:1]};
            r_t3[1] <= {sb2.val[W-1], sb2.val[W-1:1]};
            r_p4    <= n_p4;
            r_k4    <= k_p;
            r_hb4   <= r_t3[1];
            r_p5    <= n_p5;
            r_e5    <= n_e5;
            r_hb5   <= r_hb4;
            r_p6    <= n_p6;
            r_e6    <= e2.val;
            r_out   <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
endmodule
